/* src/nps_pkg.sv */
// Shared types, widths and codes for the nearest polyline segment block.
package nps_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int DW          = COORD_BITS + 1;
    localparam int MW          = DW + 1;
    localparam int PW          = 2 * MW;
    localparam int SQW         = 2 * DW;
    localparam int DOTW        = SQW + 1;
    localparam int BESTW       = SQW + 2;
    localparam int IDX_OUT_W   = 11;
    localparam int ST_W        = 2;
    localparam int DIVC_W      = $clog2(T_FRAC_BITS);

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT = 5'd1;
    localparam logic [OP_W-1:0] OP_DIFF   = 5'd2;
    localparam logic [OP_W-1:0] OP_LLX    = 5'd3;
    localparam logic [OP_W-1:0] OP_LLY    = 5'd4;
    localparam logic [OP_W-1:0] OP_DOTX   = 5'd5;
    localparam logic [OP_W-1:0] OP_DOTY   = 5'd6;
    localparam logic [OP_W-1:0] OP_DOTSUM = 5'd7;
    localparam logic [OP_W-1:0] OP_TSET   = 5'd8;
    localparam logic [OP_W-1:0] OP_DIV    = 5'd9;
    localparam logic [OP_W-1:0] OP_SCX    = 5'd10;
    localparam logic [OP_W-1:0] OP_QX     = 5'd11;
    localparam logic [OP_W-1:0] OP_QY     = 5'd12;
    localparam logic [OP_W-1:0] OP_EY     = 5'd13;
    localparam logic [OP_W-1:0] OP_EX2    = 5'd14;
    localparam logic [OP_W-1:0] OP_EY2    = 5'd15;
    localparam logic [OP_W-1:0] OP_D2SUM  = 5'd16;
    localparam logic [OP_W-1:0] OP_CMP    = 5'd17;
    localparam logic [OP_W-1:0] OP_WRAP   = 5'd18;
    localparam logic [OP_W-1:0] OP_EMIT   = 5'd19;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic                         closed_loop;
        logic                         last_vertex;
    } in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]         insert_index;
        logic signed [COORD_BITS-1:0] proj_x;
        logic signed [COORD_BITS-1:0] proj_y;
        logic [ST_W-1:0]              status;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic test_seg;
        logic last;
        logic wrap_needed;
        logic div_needed;
        logic out_free;
    } sts_t;

endpackage

/* src/nps_ctrl.sv */
// Sequencer for the nearest polyline segment block.
module nps_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nps_pkg::sts_t sts,
    output nps_pkg::cmd_t cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DIFF   = 5'd1;
    localparam logic [4:0] S_LLX    = 5'd2;
    localparam logic [4:0] S_LLY    = 5'd3;
    localparam logic [4:0] S_DOTX   = 5'd4;
    localparam logic [4:0] S_DOTY   = 5'd5;
    localparam logic [4:0] S_DOTSUM = 5'd6;
    localparam logic [4:0] S_TSET   = 5'd7;
    localparam logic [4:0] S_DIV    = 5'd8;
    localparam logic [4:0] S_SCX    = 5'd9;
    localparam logic [4:0] S_QX     = 5'd10;
    localparam logic [4:0] S_QY     = 5'd11;
    localparam logic [4:0] S_EY     = 5'd12;
    localparam logic [4:0] S_EX2    = 5'd13;
    localparam logic [4:0] S_EY2    = 5'd14;
    localparam logic [4:0] S_D2SUM  = 5'd15;
    localparam logic [4:0] S_CMP    = 5'd16;
    localparam logic [4:0] S_POST   = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;

    localparam logic [nps_pkg::DIVC_W-1:0] DIV_LAST =
        nps_pkg::DIVC_W'(nps_pkg::T_FRAC_BITS - 1);

    logic [4:0]                   state_reg, state_next;
    logic [nps_pkg::DIVC_W-1:0]   cnt_reg, cnt_next;
    logic                         wrap_reg, wrap_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wrap_next  = wrap_reg;
        cmd.op     = nps_pkg::OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = nps_pkg::OP_ACCEPT;
                    state_next = sts.test_seg ? S_DIFF : S_POST;
                end
            end
            S_DIFF:   begin cmd.op = nps_pkg::OP_DIFF;   state_next = S_LLX;    end
            S_LLX:    begin cmd.op = nps_pkg::OP_LLX;    state_next = S_LLY;    end
            S_LLY:    begin cmd.op = nps_pkg::OP_LLY;    state_next = S_DOTX;   end
            S_DOTX:   begin cmd.op = nps_pkg::OP_DOTX;   state_next = S_DOTY;   end
            S_DOTY:   begin cmd.op = nps_pkg::OP_DOTY;   state_next = S_DOTSUM; end
            S_DOTSUM: begin cmd.op = nps_pkg::OP_DOTSUM; state_next = S_TSET;   end
            S_TSET: begin
                cmd.op     = nps_pkg::OP_TSET;
                cnt_next   = '0;
                state_next = sts.div_needed ? S_DIV : S_SCX;
            end
            S_DIV: begin
                cmd.op   = nps_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_SCX;
                end
            end
            S_SCX:    begin cmd.op = nps_pkg::OP_SCX;    state_next = S_QX;     end
            S_QX:     begin cmd.op = nps_pkg::OP_QX;     state_next = S_QY;     end
            S_QY:     begin cmd.op = nps_pkg::OP_QY;     state_next = S_EY;     end
            S_EY:     begin cmd.op = nps_pkg::OP_EY;     state_next = S_EX2;    end
            S_EX2:    begin cmd.op = nps_pkg::OP_EX2;    state_next = S_EY2;    end
            S_EY2:    begin cmd.op = nps_pkg::OP_EY2;    state_next = S_D2SUM;  end
            S_D2SUM:  begin cmd.op = nps_pkg::OP_D2SUM;  state_next = S_CMP;    end
            S_CMP: begin
                cmd.op     = nps_pkg::OP_CMP;
                state_next = wrap_reg ? S_EMIT : S_POST;
            end
            S_POST: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (sts.wrap_needed) begin
                    cmd.op     = nps_pkg::OP_WRAP;
                    wrap_next  = 1'b1;
                    state_next = S_DIFF;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.op     = nps_pkg::OP_EMIT;
                    wrap_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            wrap_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wrap_reg  <= wrap_next;
        end
    end

endmodule

/* src/nps_dp.sv */
// Datapath: vertex store, shared multiplier, divider step, best-segment tracking.
module nps_dp #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  nps_pkg::in_t   s_data,
    input  nps_pkg::cmd_t  cmd,
    output nps_pkg::sts_t  sts,
    output logic           m_valid,
    input  logic           m_ready,
    output nps_pkg::out_t  m_data
);

    localparam int CW = $clog2(MAX_VERTICES + 2);
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CB = nps_pkg::COORD_BITS;
    localparam int TB = nps_pkg::T_FRAC_BITS;
    localparam int DW = nps_pkg::DW;
    localparam int MW = nps_pkg::MW;
    localparam int PW = nps_pkg::PW;
    localparam int SQW = nps_pkg::SQW;
    localparam int DOTW = nps_pkg::DOTW;
    localparam int BESTW = nps_pkg::BESTW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);
    localparam logic [PW-1:0] HALF = PW'(1) << (TB - 1);

    logic signed [CB-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CB-1:0] hq_x_reg, hq_y_reg, a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic signed [CB-1:0] qx_reg, qy_reg, best_px_reg, best_py_reg;
    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        idx_reg, best_idx_reg;
    logic                 last_reg, closed_reg, out_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg, ex_reg, ey_reg;
    logic signed [PW-1:0] prod_reg;
    logic [SQW-1:0]       l2_reg, r_reg, d2_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic [TB:0]          t_reg;
    logic [BESTW-1:0]     best_dist_reg;
    nps_pkg::out_t        out_reg;

    logic signed [MW-1:0] mul_a, mul_b;
    logic [DW-1:0]        mag_x, mag_y;
    logic                 dot_pos, dot_ge, l2_nz;
    logic [SQW-1:0]       dot_mag;
    logic [SQW:0]         r2;
    logic                 div_bit;
    logic [PW-1:0]        rnd_sum;
    logic [DW-1:0]        rnd_mag;
    logic signed [DW:0]   rnd_s, q_off, q_sum;
    logic                 q_neg;
    logic signed [CB-1:0] q_base;
    logic [nps_pkg::ST_W-1:0] code;
    logic [IW:0]          ins;

    assign mag_x = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign mag_y = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            nps_pkg::OP_LLX:  begin mul_a = MW'(dx_reg); mul_b = MW'(dx_reg); end
            nps_pkg::OP_LLY:  begin mul_a = MW'(dy_reg); mul_b = MW'(dy_reg); end
            nps_pkg::OP_DOTX: begin mul_a = MW'(wx_reg); mul_b = MW'(dx_reg); end
            nps_pkg::OP_DOTY: begin mul_a = MW'(wy_reg); mul_b = MW'(dy_reg); end
            nps_pkg::OP_SCX: begin
                mul_a = $signed(MW'(t_reg));
                mul_b = $signed(MW'(mag_x));
            end
            nps_pkg::OP_QX: begin
                mul_a = $signed(MW'(t_reg));
                mul_b = $signed(MW'(mag_y));
            end
            nps_pkg::OP_EX2:  begin mul_a = MW'(ex_reg); mul_b = MW'(ex_reg); end
            nps_pkg::OP_EY2:  begin mul_a = MW'(ey_reg); mul_b = MW'(ey_reg); end
            default: ;
        endcase
    end

    assign l2_nz   = (l2_reg != '0);
    assign dot_pos = !dot_reg[DOTW-1] && (dot_reg != '0);
    assign dot_mag = dot_reg[SQW-1:0];
    assign dot_ge  = (dot_mag >= l2_reg);

    assign r2      = {r_reg, 1'b0};
    assign div_bit = (r2 >= {1'b0, l2_reg});

    assign rnd_sum = prod_reg + HALF;
    assign rnd_mag = rnd_sum[TB+DW-1:TB];
    assign rnd_s   = $signed({1'b0, rnd_mag});
    assign q_neg   = (cmd.op == nps_pkg::OP_QY) ? dy_reg[DW-1] : dx_reg[DW-1];
    assign q_base  = (cmd.op == nps_pkg::OP_QY) ? a_y_reg : a_x_reg;
    assign q_off   = q_neg ? -rnd_s : rnd_s;
    assign q_sum   = (DW+1)'(q_base) + q_off;

    always_comb begin
        if (count_reg > CNT_MAX) begin
            code = nps_pkg::ST_OVERFLOW;
        end else if (count_reg < CNT_TWO) begin
            code = nps_pkg::ST_TOO_FEW;
        end else begin
            code = nps_pkg::ST_OK;
        end
    end

    assign ins = {1'b0, best_idx_reg} + 1'b1;

    assign sts.test_seg    = (count_reg != '0) && (count_reg < CNT_MAX);
    assign sts.last        = last_reg;
    assign sts.wrap_needed = closed_reg && (code == nps_pkg::ST_OK);
    assign sts.div_needed  = l2_nz && dot_pos && !dot_ge;
    assign sts.out_free    = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            nps_pkg::OP_ACCEPT: begin
                if (count_reg == '0) begin
                    hq_x_reg    <= s_data.query_x;
                    hq_y_reg    <= s_data.query_y;
                    first_x_reg <= s_data.vertex_x;
                    first_y_reg <= s_data.vertex_y;
                end
                a_x_reg    <= prev_x_reg;
                a_y_reg    <= prev_y_reg;
                b_x_reg    <= s_data.vertex_x;
                b_y_reg    <= s_data.vertex_y;
                prev_x_reg <= s_data.vertex_x;
                prev_y_reg <= s_data.vertex_y;
                idx_reg    <= IW'(count_reg - 1'b1);
                last_reg   <= s_data.last_vertex;
                closed_reg <= s_data.closed_loop;
            end
            nps_pkg::OP_WRAP: begin
                a_x_reg <= prev_x_reg;
                a_y_reg <= prev_y_reg;
                b_x_reg <= first_x_reg;
                b_y_reg <= first_y_reg;
                idx_reg <= IW'(count_reg - 1'b1);
            end
            nps_pkg::OP_DIFF: begin
                dx_reg <= DW'(b_x_reg) - DW'(a_x_reg);
                dy_reg <= DW'(b_y_reg) - DW'(a_y_reg);
                wx_reg <= DW'(hq_x_reg) - DW'(a_x_reg);
                wy_reg <= DW'(hq_y_reg) - DW'(a_y_reg);
            end
            nps_pkg::OP_LLY:    l2_reg  <= SQW'(prod_reg);
            nps_pkg::OP_DOTX:   l2_reg  <= l2_reg + SQW'(prod_reg);
            nps_pkg::OP_DOTY:   dot_reg <= DOTW'(prod_reg);
            nps_pkg::OP_DOTSUM: dot_reg <= dot_reg + DOTW'(prod_reg);
            nps_pkg::OP_TSET: begin
                t_reg <= (l2_nz && dot_pos && dot_ge) ? nps_pkg::T_ONE : '0;
                r_reg <= dot_mag;
            end
            nps_pkg::OP_DIV: begin
                t_reg <= {t_reg[TB-1:0], div_bit};
                r_reg <= div_bit ? SQW'(r2 - {1'b0, l2_reg}) : SQW'(r2);
            end
            nps_pkg::OP_QX: qx_reg <= CB'(q_sum);
            nps_pkg::OP_QY: begin
                qy_reg <= CB'(q_sum);
                ex_reg <= DW'(hq_x_reg) - DW'(qx_reg);
            end
            nps_pkg::OP_EY:    ey_reg <= DW'(hq_y_reg) - DW'(qy_reg);
            nps_pkg::OP_EY2:   d2_reg <= SQW'(prod_reg);
            nps_pkg::OP_D2SUM: d2_reg <= d2_reg + SQW'(prod_reg);
            nps_pkg::OP_CMP: begin
                if (BESTW'(d2_reg) < best_dist_reg) begin
                    best_idx_reg <= idx_reg;
                    best_px_reg  <= qx_reg;
                    best_py_reg  <= qy_reg;
                end
            end
            nps_pkg::OP_EMIT: begin
                out_reg.status <= code;
                if (code == nps_pkg::ST_OK) begin
                    out_reg.insert_index <= nps_pkg::IDX_OUT_W'(ins);
                    out_reg.proj_x       <= best_px_reg;
                    out_reg.proj_y       <= best_py_reg;
                end else begin
                    out_reg.insert_index <= '0;
                    out_reg.proj_x       <= '0;
                    out_reg.proj_y       <= '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            best_dist_reg <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == nps_pkg::OP_ACCEPT && count_reg <= CNT_MAX) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.op == nps_pkg::OP_CMP && BESTW'(d2_reg) < best_dist_reg) begin
                best_dist_reg <= BESTW'(d2_reg);
            end
            if (cmd.op == nps_pkg::OP_EMIT) begin
                count_reg     <= '0;
                best_dist_reg <= '1;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == nps_pkg::OP_CMP) |=> (best_dist_reg <= $past(best_dist_reg)))
        else $error("best distance grew on a compare");

    a_t_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == nps_pkg::OP_SCX) |-> (t_reg <= nps_pkg::T_ONE))
        else $error("projection parameter above one");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX + 1'b1)
        else $error("vertex count past saturation");

    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.op == nps_pkg::OP_EMIT))
        else $error("result raised without emit");

endmodule

/* src/nearest_polyline_segment.sv */
// Nearest polyline segment: vertices stream in one item each; the final item
// yields the insert index, the projected point and a status. A first vertex, or
// one past MAX_VERTICES, is only stored; a vertex that closes a segment runs a
// segment test on the single shared 26x26 multiplier, with the 16-step restoring
// divider for t skipped when the projection clamps. The last item of a closed
// polyline with status OK adds one more segment test for the wrap segment before
// the result is loaded. The result sits in an output register, so a new polyline
// may start while it waits to be taken.
module nearest_polyline_segment #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nps_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output nps_pkg::out_t m_data
);

    nps_pkg::cmd_t cmd;
    nps_pkg::sts_t sts;

    nps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nps_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/sv/tb_nearest_polyline_segment.sv */
// Testbench for the nearest polyline segment block: streamed polylines checked against a predictor.
`timescale 1ns / 1ps

module tb_nearest_polyline_segment;

    localparam int MAXV      = 1024;
    localparam int CB        = nps_pkg::COORD_BITS;
    localparam int CMAX      = 8388607;
    localparam int CMIN      = -8388608;
    localparam longint LIMIT = 4000000;

    class nps_scoreboard;
        longint fx, fy, px, py, hqx, hqy;
        int     vcount;
        longint best_d2;
        int     best_seg;
        longint bpx, bpy;
        nps_pkg::out_t pending[$];
        int     errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            fx = 0; fy = 0; px = 0; py = 0; hqx = 0; hqy = 0;
            vcount = 0;
            best_d2 = -1;
            best_seg = 0;
            bpx = 0; bpy = 0;
        endfunction

        function longint round_scale(longint t, longint d);
            longint mag, r;
            mag = (d < 0) ? -d : d;
            r = (t * mag + (64'sd1 <<< (nps_pkg::T_FRAC_BITS - 1))) >>> nps_pkg::T_FRAC_BITS;
            return (d < 0) ? -r : r;
        endfunction

        function void project(longint ax, longint ay, longint bx, longint by, int idx);
            longint dx, dy, wx, wy, l2, dot, t, r, qx, qy, ex, ey, d2;
            dx = bx - ax; dy = by - ay;
            wx = hqx - ax; wy = hqy - ay;
            l2 = dx * dx + dy * dy;
            dot = wx * dx + wy * dy;
            t = 0;
            if (l2 != 0 && dot > 0) begin
                if (dot >= l2) begin
                    t = 64'sd1 <<< nps_pkg::T_FRAC_BITS;
                end else begin
                    r = dot;
                    for (int i = 0; i < nps_pkg::T_FRAC_BITS; i++) begin
                        t = t << 1;
                        if (r >= l2 - r) begin
                            r = r - (l2 - r);
                            t = t | 1;
                        end else begin
                            r = r + r;
                        end
                    end
                end
            end
            qx = ax + round_scale(t, dx);
            qy = ay + round_scale(t, dy);
            ex = hqx - qx; ey = hqy - qy;
            d2 = ex * ex + ey * ey;
            if (best_d2 < 0 || d2 < best_d2) begin
                best_d2 = d2; best_seg = idx; bpx = qx; bpy = qy;
            end
        endfunction

        function void note_input(nps_pkg::in_t it);
            longint vx, vy;
            nps_pkg::out_t o;
            vx = longint'(it.vertex_x); vy = longint'(it.vertex_y);
            if (vcount == 0) begin
                hqx = longint'(it.query_x); hqy = longint'(it.query_y);
                fx = vx; fy = vy;
            end else if (vcount < MAXV) begin
                project(px, py, vx, vy, vcount - 1);
            end
            if (vcount <= MAXV) vcount++;
            px = vx; py = vy;
            if (!it.last_vertex) return;
            o = '0;
            if (vcount > MAXV) begin
                o.status = nps_pkg::ST_OVERFLOW;
            end else if (vcount < 2) begin
                o.status = nps_pkg::ST_TOO_FEW;
            end else begin
                o.status = nps_pkg::ST_OK;
                if (it.closed_loop) project(px, py, fx, fy, vcount - 1);
                o.insert_index = nps_pkg::IDX_OUT_W'(best_seg + 1);
                o.proj_x = CB'(bpx);
                o.proj_y = CB'(bpy);
            end
            pending.push_back(o);
            clear();
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(nps_pkg::out_t got);
            nps_pkg::out_t want;
            if (pending.size() == 0) begin
                report("unexpected result item", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.insert_index !== want.insert_index)
                report("insert_index", got.insert_index, want.insert_index);
            if (got.proj_x !== want.proj_x) report("proj_x", got.proj_x, want.proj_x);
            if (got.proj_y !== want.proj_y) report("proj_y", got.proj_y, want.proj_y);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    nps_pkg::in_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    nps_pkg::out_t m_data;

    nps_scoreboard sb = new();
    longint cycles = 0;
    bit     stim_done = 0;

    nearest_polyline_segment #(.MAX_VERTICES(MAXV)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // result side: random stall before taking each item
    initial begin
        int w;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send(nps_pkg::in_t it);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? CMAX : CMIN;
            1: return $signed($urandom_range(0, 200)) - 100;
            2: return $signed($urandom_range(0, 65535)) - 32768;
            default: return $signed(24'($urandom));
        endcase
    endfunction

    task automatic send_vertex(int vx, int vy, int qx, int qy, bit cl, bit lst);
        nps_pkg::in_t it;
        it.vertex_x = CB'(vx); it.vertex_y = CB'(vy);
        it.query_x = CB'(qx); it.query_y = CB'(qy);
        it.closed_loop = cl; it.last_vertex = lst;
        send(it);
    endtask

    task automatic random_polyline(int n, int mode, bit cl);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_vertex(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                            1'($urandom_range(0, 1)), i == n - 1);
            else
                send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                            rand_coord(mode), (i == n - 1) ? cl : 1'($urandom_range(0, 1)),
                            i == n - 1);
        end
    endtask

    initial begin
        int sent, n;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: too few, two-vertex open/closed, extremes, degenerate, ties
        send_vertex(5, 5, 1, 1, 0, 1);
        send_vertex(0, 0, 3, 4, 0, 0); send_vertex(10, 0, 0, 0, 0, 1);
        send_vertex(0, 0, 5, 5, 1, 0); send_vertex(10, 0, 0, 0, 1, 1);
        send_vertex(CMIN, CMIN, CMAX, CMAX, 0, 0); send_vertex(CMAX, CMAX, 0, 0, 0, 1);
        send_vertex(CMAX, CMIN, CMIN, CMAX, 1, 0); send_vertex(CMIN, CMAX, 0, 0, 1, 1);
        send_vertex(7, 7, 0, 0, 0, 0); send_vertex(7, 7, 0, 0, 0, 1);
        send_vertex(-1, 0, 0, 5, 0, 0); send_vertex(1, 0, 0, 0, 0, 0);
        send_vertex(-1, 0, 0, 0, 0, 1);
        send_vertex(0, 0, 1, 1, 0, 0); send_vertex(3, 0, 0, 0, 0, 0);
        send_vertex(3, 3, 0, 0, 1, 1);
        send_vertex(0, 0, 20, -9, 0, 0); send_vertex(10, 0, 0, 0, 0, 1);
        sent = 19;

        // one overflow run past the vertex limit
        random_polyline(MAXV + 3, 2, 1);
        sent += MAXV + 3;

        while (sent < 1300) begin
            n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
            random_polyline(n, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            sent += n;
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
